@@ hdl/planar_glyph_blitter_defines.svh @@
// Assertion macros shared by the blitter RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef PLANAR_GLYPH_BLITTER_DEFINES_SVH
`define PLANAR_GLYPH_BLITTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PGB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("blitter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PGB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("blitter check failed");

`endif

@@ hdl/pgb_pkg.sv @@
// Shared constants, codes and types for the planar glyph blitter.
// Depends on nothing.
package pgb_pkg;

	localparam int GLYPH_COUNT  = 128;
	localparam int ROW_BYTES    = 80;
	localparam int GLYPH_HEIGHT = 5;
	localparam int PLANES       = 4;
	localparam int MAP_DEPTH    = 256;
	localparam int ROW_DEPTH    = GLYPH_COUNT * GLYPH_HEIGHT;
	localparam int ROW_AW       = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
	localparam int PIX_COUNT    = PLANES * GLYPH_HEIGHT;
	localparam int ROW_IDX_W    = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
	localparam int FETCH_W      = $clog2(GLYPH_HEIGHT + 1);

	// Request codes
	localparam logic [1:0] FUNC_LOAD_MAP   = 2'd0;
	localparam logic [1:0] FUNC_LOAD_GLYPH = 2'd1;
	localparam logic [1:0] FUNC_RENDER     = 2'd2;

	// Register indexes
	localparam logic [1:0] CFG_FRAME_BASE  = 2'd0;
	localparam logic [1:0] CFG_START_X     = 2'd1;
	localparam logic [1:0] CFG_START_Y     = 2'd2;
	localparam logic [1:0] CFG_PIXEL_COLOR = 2'd3;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MAP   = 5'b00010,
		ST_FETCH = 5'b00100,
		ST_LOAD  = 5'b01000,
		ST_DRAW  = 5'b10000
	} state_t;

	typedef struct packed {
		logic              map_we;
		logic              map_re;
		logic [7:0]        map_addr;
		logic              row_we;
		logic              row_re;
		logic [ROW_AW-1:0] row_addr;
		logic [7:0]        wdata;
	} tbl_req_t;

endpackage

@@ hdl/pgb_tables.sv @@
// Character map and glyph row memories, one access per memory per cycle.
// Depends on pgb_pkg.
module pgb_tables (
	input  logic              clk,
	input  pgb_pkg::tbl_req_t req,
	output logic [7:0]        map_rdata,
	output logic [7:0]        row_rdata
);
	import pgb_pkg::*;

	logic [7:0] map_mem [MAP_DEPTH];
	logic [7:0] row_mem [ROW_DEPTH];

	always_ff @(posedge clk) begin
		if (req.map_we) begin
			map_mem[req.map_addr] <= req.wdata;
		end
		if (req.map_re) begin
			map_rdata <= map_mem[req.map_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.row_we) begin
			row_mem[req.row_addr] <= req.wdata;
		end
		if (req.row_re) begin
			row_rdata <= row_mem[req.row_addr];
		end
	end

endmodule

@@ hdl/planar_glyph_blitter.sv @@
// Planar glyph blitter top level; uses pgb_pkg, pgb_tables and the defines header.
// Load requests write their table on accept; a zero char requests a cursor reload, and a
// glyph index that draws nothing only advances the cursor. A render looks up and fetches its
// glyph, then steps through its pixels up to the last set one (at most 20), held by write stalls.
// One shared offset adder and one framebuffer write slot set the pace of the draw pass.
// Reset clears control and registers and reloads the cursor before the first request.
module planar_glyph_blitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [9:0]  table_address,
	input  logic [7:0]  table_data,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] write_offset,
	output logic [3:0]  plane_mask,
	output logic [7:0]  pixel_value,
	output logic        last_write
);
	import pgb_pkg::*;
	`include "planar_glyph_blitter_defines.svh"

	// Configuration registers
	logic [15:0] frame_base_q;
	logic [8:0]  start_x_q;
	logic [7:0]  start_y_q;
	logic [7:0]  pixel_color_q;

	// Sequencer and cursor
	state_t               state_q;
	logic                 reload_pending_q;
	logic [15:0]          cursor_q;
	logic [ROW_AW-1:0]    row_rd_addr_q;
	logic [FETCH_W-1:0]   fetch_cnt_q;
	logic [PLANES-1:0]    rows_q [GLYPH_HEIGHT];
	logic [PIX_COUNT-1:0] pix_q;
	logic [1:0]           col_q;
	logic [ROW_IDX_W-1:0] row_q;
	logic [15:0]          row_off_q;

	// Output register
	logic        out_valid_q;
	logic [15:0] offset_q;
	logic [3:0]  mask_q;
	logic [7:0]  color_q;
	logic        last_q;

	tbl_req_t   tbl_req;
	logic [7:0] map_rdata;
	logic [7:0] row_rdata;

	logic                 accept;
	logic                 glyph_ok;
	logic [ROW_AW-1:0]    glyph_base;
	logic [15:0]          reload_val;
	logic                 slot_free;
	logic                 draw_step;
	logic                 draw_done;
	logic                 out_load;
	logic [2:0]           plane_sum;
	logic [15:0]          offset_d;
	logic [FETCH_W-1:0]   fetch_prev;
	logic [PIX_COUNT-1:0] pix_d;

	assign accept = in_valid && !in_stall;
	// Hold requests while working and for the cycle in which the cursor reloads.
	assign in_stall = (state_q != ST_IDLE) || reload_pending_q;

	// Cursor reload point: base + start row * bytes per row + start byte column.
	assign reload_val = frame_base_q + 16'(int'(start_y_q) * ROW_BYTES)
		+ {7'd0, start_x_q[8:2]};

	// Glyph indexes with the top bit set, or past the font, draw nothing.
	assign glyph_ok   = (map_rdata[7] == 1'b0) && (int'(map_rdata) < GLYPH_COUNT);
	assign glyph_base = ROW_AW'(int'(map_rdata) * GLYPH_HEIGHT);

	// Table accesses: loads write on accept, render reads map then rows.
	always_comb begin
		tbl_req          = '0;
		tbl_req.wdata    = table_data;
		tbl_req.map_addr = table_address[7:0];
		tbl_req.row_addr = ROW_AW'(table_address);
		if (accept) begin
			case (func)
				FUNC_LOAD_MAP: begin
					tbl_req.map_we = (int'(table_address) < MAP_DEPTH);
				end
				FUNC_LOAD_GLYPH: begin
					tbl_req.row_we = (int'(table_address) < ROW_DEPTH);
				end
				FUNC_RENDER: begin
					tbl_req.map_addr = char_code;
					tbl_req.map_re   = (char_code != 8'd0);
				end
				default: begin
				end
			endcase
		end else if (state_q == ST_FETCH) begin
			tbl_req.row_addr = row_rd_addr_q;
			tbl_req.row_re   = (int'(fetch_cnt_q) < GLYPH_HEIGHT);
		end
	end

	pgb_tables u_tables (
		.clk       (clk),
		.req       (tbl_req),
		.map_rdata (map_rdata),
		.row_rdata (row_rdata)
	);

	// Pixel order: column pass by column pass, rows inside a pass.
	always_comb begin
		for (int c = 0; c < PLANES; c++) begin
			for (int r = 0; r < GLYPH_HEIGHT; r++) begin
				pix_d[c * GLYPH_HEIGHT + r] = rows_q[r][PLANES - 1 - c];
			end
		end
	end

	assign fetch_prev = fetch_cnt_q - FETCH_W'(1);

	// Shared offset adder: cursor plus byte carry plus accumulated row offset.
	assign plane_sum = {1'b0, start_x_q[1:0]} + {1'b0, col_q};
	assign offset_d  = cursor_q + {15'd0, plane_sum[2]} + row_off_q;

	// Advance one pixel whenever the output slot can take a request.
	assign slot_free = !out_valid_q || !out_stall;
	assign draw_step = (state_q == ST_DRAW) && slot_free;
	assign draw_done = (pix_q[PIX_COUNT-1:1] == '0);
	assign out_load  = draw_step && pix_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q     <= '0;
			start_x_q        <= '0;
			start_y_q        <= '0;
			pixel_color_q    <= '0;
			state_q          <= ST_IDLE;
			reload_pending_q <= 1'b1;
			cursor_q         <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FRAME_BASE:  frame_base_q  <= cfg_data;
					CFG_START_X:     start_x_q     <= cfg_data[8:0];
					CFG_START_Y:     start_y_q     <= cfg_data[7:0];
					CFG_PIXEL_COLOR: pixel_color_q <= cfg_data[7:0];
					default: begin
					end
				endcase
				reload_pending_q <= 1'b1;
			end else if (reload_pending_q) begin
				cursor_q         <= reload_val;
				reload_pending_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && (func == FUNC_RENDER)) begin
						if (char_code == 8'd0) begin
							// End of string: request a cursor reload.
							reload_pending_q <= 1'b1;
						end else begin
							state_q <= ST_MAP;
						end
					end
				end
				ST_MAP: begin
					if (glyph_ok) begin
						state_q <= ST_FETCH;
					end else begin
						cursor_q <= cursor_q + 16'd1;
						state_q  <= ST_IDLE;
					end
				end
				ST_FETCH: begin
					if (int'(fetch_cnt_q) == GLYPH_HEIGHT) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_DRAW;
				end
				ST_DRAW: begin
					if (draw_step && draw_done) begin
						cursor_q <= cursor_q + 16'd1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers: no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_MAP: begin
				row_rd_addr_q <= glyph_base;
				fetch_cnt_q   <= '0;
			end
			ST_FETCH: begin
				row_rd_addr_q <= row_rd_addr_q + ROW_AW'(1);
				fetch_cnt_q   <= fetch_cnt_q + FETCH_W'(1);
				if (fetch_cnt_q != '0) begin
					rows_q[fetch_prev[ROW_IDX_W-1:0]] <= row_rdata[7 -: PLANES];
				end
			end
			ST_LOAD: begin
				pix_q     <= pix_d;
				col_q     <= '0;
				row_q     <= '0;
				row_off_q <= '0;
			end
			ST_DRAW: begin
				if (draw_step) begin
					pix_q <= pix_q >> 1;
					if (int'(row_q) == GLYPH_HEIGHT - 1) begin
						row_q     <= '0;
						col_q     <= col_q + 2'd1;
						row_off_q <= '0;
					end else begin
						row_q     <= row_q + ROW_IDX_W'(1);
						row_off_q <= row_off_q + 16'(ROW_BYTES);
					end
				end
			end
			default: begin
			end
		endcase

		if (out_load) begin
			offset_q <= offset_d;
			mask_q   <= 4'd1 << plane_sum[1:0];
			color_q  <= pixel_color_q;
			last_q   <= draw_done;
		end
	end

	assign out_valid    = out_valid_q;
	assign write_offset = offset_q;
	assign plane_mask   = mask_q;
	assign pixel_value  = color_q;
	assign last_write   = last_q;

	// The final write of a character always closes the draw pass.
	`PGB_ASSERT_NEXT(a_last_ends_draw, out_load && draw_done, state_q == ST_IDLE)
	// No framebuffer write is produced outside the draw pass.
	`PGB_ASSERT_NOW(a_no_write_outside_draw, state_q != ST_DRAW, !out_load)
	// The draw pass is entered only after the glyph rows were latched.
	`PGB_ASSERT_NOW(a_draw_after_load, $rose(state_q == ST_DRAW), $past(state_q) == ST_LOAD)
	// A pending cursor reload always blocks new requests.
	`PGB_ASSERT_NOW(a_reload_blocks, reload_pending_q, in_stall)

endmodule
